// ----- hw/rtl/lkxm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkxm_pkg: shared types and constants of the keystream XOR masker
// Generator constants, size and register codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package lkxm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // chunk size codes
  localparam logic [CODE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [CODE_W-1:0] SIZE_HALF = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVOLVING  = 1'b1;

  typedef enum logic [2:0] {
    ADV_NONE       = 3'd0,
    ADV_START_SEED = 3'd1,
    ADV_START_KEY  = 3'd2,
    ADV_SHIFT1     = 3'd3,
    ADV_SHIFT2     = 3'd4,
    ADV_FINISH     = 3'd5
  } adv_op_e;

  typedef struct packed {
    logic    load_in;
    adv_op_e adv_op;
    logic    emit;
  } lkxm_cmd_t;

  typedef struct packed {
    logic evolving;
    logic out_free;
  } lkxm_sts_t;

  // one linear congruential update, modulo 2^32
  function automatic logic [31:0] lcg_step(input logic [31:0] x);
    logic [31:0] prod;
    prod = x * LCG_MUL;
    return prod + LCG_ADD;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lkxm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkxm_in_if: input chunk channel
// Valid/ready channel carrying one chunk per transaction.
// ----------------------------------------------------------------------------
interface lkxm_in_if;
  logic                          valid;
  logic                          ready;
  logic [lkxm_pkg::DATA_W-1:0]   chunk_data;
  logic [lkxm_pkg::CODE_W-1:0]   chunk_size_code;
  logic                          first_chunk;

  modport source (output valid, output chunk_data, output chunk_size_code,
                  output first_chunk, input ready);
  modport sink   (input valid, input chunk_data, input chunk_size_code,
                  input first_chunk, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lkxm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkxm_out_if: masked chunk channel
// Valid/ready channel carrying one masked chunk per transaction.
// ----------------------------------------------------------------------------
interface lkxm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lkxm_pkg::DATA_W-1:0]   masked_data;
  logic [lkxm_pkg::CODE_W-1:0]   out_size_code;

  modport source (output valid, output masked_data, output out_size_code,
                  input ready);
  modport sink   (input valid, input masked_data, input out_size_code,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lkxm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkxm_datapath: key generator, chunk masking and output register
// Holds config, running key, one shared LCG multiplier and the result slot.
// ----------------------------------------------------------------------------
module lkxm_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lkxm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lkxm_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  wire logic [lkxm_pkg::DATA_W-1:0]        chunk_data_i,
  input  wire logic [lkxm_pkg::CODE_W-1:0]        chunk_size_code_i,
  input  wire lkxm_pkg::lkxm_cmd_t                cmd_i,
  output lkxm_pkg::lkxm_sts_t                     sts_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [lkxm_pkg::DATA_W-1:0]             masked_data_o,
  output logic [lkxm_pkg::CODE_W-1:0]             out_size_code_o
);

  logic [31:0] seed_q, seed_d;
  logic        evo_q, evo_d;
  logic [31:0] key_q, key_d;
  logic [31:0] x_q, x_d;
  logic [30:0] r_q, r_d;
  logic [31:0] data_q;
  logic [1:0]  code_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  logic [1:0]  out_code_q;

  logic [31:0] mul_src;
  logic [31:0] lcg_val;
  logic [31:0] key_use;
  logic [31:0] xored;
  logic [31:0] masked;

  // configuration writes
  always_comb begin
    seed_d = seed_q;
    evo_d  = evo_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lkxm_pkg::CFG_KEY_SEED: seed_d = cfg_wdata_i;
        lkxm_pkg::CFG_EVOLVING: evo_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // key generator: one multiply per cycle, three updates per advance
  always_comb begin
    case (cmd_i.adv_op)
      lkxm_pkg::ADV_START_SEED: mul_src = seed_q;
      lkxm_pkg::ADV_START_KEY:  mul_src = key_q;
      default:                  mul_src = x_q;
    endcase
    lcg_val = lkxm_pkg::lcg_step(mul_src);

    x_d   = x_q;
    r_d   = r_q;
    key_d = key_q;
    case (cmd_i.adv_op)
      lkxm_pkg::ADV_START_SEED,
      lkxm_pkg::ADV_START_KEY: begin
        x_d = lcg_val;
      end
      lkxm_pkg::ADV_SHIFT1: begin
        r_d = {20'b0, x_q[26:16]};
        x_d = lcg_val;
      end
      lkxm_pkg::ADV_SHIFT2: begin
        r_d = {r_q[20:0], x_q[25:16]};
        x_d = lcg_val;
      end
      lkxm_pkg::ADV_FINISH: begin
        key_d = {1'b0, r_q[20:0], x_q[25:16]};
      end
      default: ;
    endcase
  end

  // masking: key low bits over the chunk width, upper bits zero
  always_comb begin
    key_use = evo_q ? key_q : seed_q;
    xored   = data_q ^ key_use;
    case (code_q)
      lkxm_pkg::SIZE_BYTE: masked = {24'b0, xored[7:0]};
      lkxm_pkg::SIZE_HALF: masked = {16'b0, xored[15:0]};
      default:             masked = xored;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      evo_q       <= 1'b0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      evo_q       <= evo_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
    if (cmd_i.load_in) begin
      data_q <= chunk_data_i;
      code_q <= chunk_size_code_i;
    end
    if (cmd_i.emit) begin
      out_data_q <= masked;
      out_code_q <= code_q;
    end
  end

  assign sts_o.evolving = evo_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign masked_data_o   = out_data_q;
  assign out_size_code_o = out_code_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lkxm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkxm_ctrl: sequencing controller
// Steps accept, key advance and result emission for one chunk at a time.
// ----------------------------------------------------------------------------
module lkxm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 first_chunk_i,
  input  wire lkxm_pkg::lkxm_sts_t  sts_i,
  output lkxm_pkg::lkxm_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PRE_ADV  = 4'b0010,
    ST_EMIT     = 4'b0100,
    ST_POST_ADV = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;

  // map advance step to datapath operation
  function automatic lkxm_pkg::adv_op_e step_op(input logic [1:0] step,
                                                input logic from_seed);
    lkxm_pkg::adv_op_e op;
    case (step)
      2'd0:    op = from_seed ? lkxm_pkg::ADV_START_SEED : lkxm_pkg::ADV_START_KEY;
      2'd1:    op = lkxm_pkg::ADV_SHIFT1;
      2'd2:    op = lkxm_pkg::ADV_SHIFT2;
      default: op = lkxm_pkg::ADV_FINISH;
    endcase
    return op;
  endfunction

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.adv_op  = lkxm_pkg::ADV_NONE;
    cmd_o.emit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = 2'd0;
          state_d       = (sts_i.evolving && first_chunk_i) ? ST_PRE_ADV : ST_EMIT;
        end
      end
      ST_PRE_ADV: begin
        cmd_o.adv_op = step_op(step_q, 1'b1);
        step_d       = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          step_d     = 2'd0;
          state_d    = sts_i.evolving ? ST_POST_ADV : ST_IDLE;
        end
      end
      ST_POST_ADV: begin
        cmd_o.adv_op = step_op(step_q, 1'b0);
        step_d       = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lcg_keystream_xor_masker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted chunk is registered, then its masked result is registered into the
// output register once that is free; on a buffer's first chunk in evolving mode the
// seed advance comes first. A chunk is accepted only once the block is idle again: after
// emission and, in evolving mode, after the single shared LCG multiplier advanced the key.
// Reset: asynchronous, active low; clears seed, mode, running key and all handshakes.
// ----------------------------------------------------------------------------
// lcg_keystream_xor_masker_top: keystream XOR masker
// XOR-masks byte, half-word or word chunks with a fixed or LCG-evolved key.
// ----------------------------------------------------------------------------
module lcg_keystream_xor_masker_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lkxm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lkxm_pkg::DATA_W-1:0]      cfg_wdata_i,
  lkxm_in_if.sink                               in_ch,
  lkxm_out_if.source                            out_ch
);

  // command and status between controller and datapath
  lkxm_pkg::lkxm_cmd_t cmd;
  lkxm_pkg::lkxm_sts_t sts;

  // The controller accepts a transaction only when idle. The result sits in
  // the datapath's output register, so a new chunk can be taken while the
  // previous result still waits for the sink.
  lkxm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_o    (in_ch.ready),
    .first_chunk_i (in_ch.first_chunk),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Datapath: config registers, running key, the shared multiplier that
  // advances the key (three updates, one per cycle, plus a finish step),
  // the masking logic and the output register.
  lkxm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .chunk_data_i      (in_ch.chunk_data),
    .chunk_size_code_i (in_ch.chunk_size_code),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .masked_data_o     (out_ch.masked_data),
    .out_size_code_o   (out_ch.out_size_code)
  );

endmodule
`default_nettype wire

// ----- tb/sv/lkxm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkxm_checker: scoreboard for the keystream XOR masker
// Watches the configuration port and both chunk channels, predicts each
// masked chunk from its own key state and compares it with the block's output.
// ----------------------------------------------------------------------------
module lkxm_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lkxm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lkxm_pkg::DATA_W-1:0]      cfg_wdata_i,
  lkxm_in_if                                    in_mon,
  lkxm_out_if                                   out_mon,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o
);
  import lkxm_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] masked;
    logic [CODE_W-1:0] size;
  } masked_chunk_t;

  masked_chunk_t       expected_chunks[$];
  logic [DATA_W-1:0]   seed_q      = '0;
  logic                evolving_q  = 1'b0;
  logic [DATA_W-1:0]   keystream_q = '0;
  int unsigned         fail_count  = 0;
  int unsigned         pending     = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // three LCG updates, keeping 11 + 10 + 10 bits from bit 16 upward
  function automatic logic [DATA_W-1:0] advance_key(input logic [DATA_W-1:0] k);
    logic [DATA_W-1:0] x;
    logic [30:0]       bits;
    x = k * LCG_MUL + LCG_ADD;
    bits[30:20] = x[26:16];
    x = x * LCG_MUL + LCG_ADD;
    bits[19:10] = x[25:16];
    x = x * LCG_MUL + LCG_ADD;
    bits[9:0] = x[25:16];
    return {1'b0, bits};
  endfunction

  function automatic logic [DATA_W-1:0] mask_to_size(input logic [DATA_W-1:0] v,
                                                     input logic [CODE_W-1:0] size);
    case (size)
      SIZE_BYTE: return {24'h0, v[7:0]};
      SIZE_HALF: return {16'h0, v[15:0]};
      default:   return v;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] got_v);
    $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  task automatic predict_chunk();
    logic [DATA_W-1:0] key;
    masked_chunk_t     exp_c;
    if (evolving_q) begin
      if (in_mon.first_chunk) keystream_q = advance_key(seed_q);
      key = keystream_q;
    end else begin
      key = seed_q;
    end
    exp_c.masked = mask_to_size(in_mon.chunk_data ^ key, in_mon.chunk_size_code);
    exp_c.size   = in_mon.chunk_size_code;
    expected_chunks.push_back(exp_c);
    // advance after every chunk, the last one of a buffer included
    if (evolving_q) keystream_q = advance_key(keystream_q);
  endtask

  task automatic check_result();
    masked_chunk_t exp_c;
    if (expected_chunks.size() == 0) begin
      report_mismatch("result with nothing pending", '0, out_mon.masked_data);
    end else begin
      exp_c = expected_chunks.pop_front();
      if (exp_c.masked !== out_mon.masked_data)
        report_mismatch("masked_data", exp_c.masked, out_mon.masked_data);
      if (exp_c.size !== out_mon.out_size_code)
        report_mismatch("out_size_code", 32'(exp_c.size), 32'(out_mon.out_size_code));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      = '0;
      evolving_q  = 1'b0;
      keystream_q = '0;
      expected_chunks.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_SEED: seed_q = cfg_wdata_i;
          CFG_EVOLVING: evolving_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_chunk();
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending = expected_chunks.size();
  end

endmodule

// ----- tb/sv/lcg_keystream_xor_masker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_keystream_xor_masker_top_tb: regression bench for the keystream masker
// Drives directed and random chunk streams through fixed and evolving key
// settings with random idling and back-pressure; a checker module predicts
// and compares every masked chunk, and this top gives the verdict.
// ----------------------------------------------------------------------------
module lcg_keystream_xor_masker_top_tb;
  import lkxm_pkg::*;

  // size codes the package does not name
  localparam logic [CODE_W-1:0] SIZE_WORD = 2'd2;
  localparam logic [CODE_W-1:0] SIZE_ODD  = 2'd3;

  localparam int unsigned RX_HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned QUIET_LIMIT    = 4000;  // cycles without a transaction
  localparam int unsigned DRAIN_CYCLES   = 20;    // longer than the longest item time
  localparam int unsigned PHASE_ITEMS    = 72;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [DATA_W-1:0]      cfg_wdata;

  // idling switches and hold-off handshake between stimulus and receiver
  bit                     tx_idle_en = 1'b1;
  bit                     rx_idle_en = 1'b1;
  int unsigned            hold_requests = 0;
  int unsigned            holds_served  = 0;

  int unsigned            fail_count;
  int unsigned            pending;

  lkxm_in_if  in_ch ();
  lkxm_out_if out_ch ();

  lcg_keystream_xor_masker_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  lkxm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("lcg_keystream_xor_masker_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver: drop ready at random while idling is on; on request hold it
  // low for a long stretch so the block backs up and stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ch.ready <= !rx_idle_en || ($urandom_range(99) >= 24);
      end
    end
  end

  // Offer one chunk from the next falling edge and hold it until the
  // transaction completes. Valid stays high on return; the next call
  // either keeps it up or drops it, one assignment per edge.
  task automatic send_chunk(input logic [DATA_W-1:0] data, input logic [CODE_W-1:0] size,
                            input logic first);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.chunk_data      <= data;
    in_ch.chunk_size_code <= size;
    in_ch.first_chunk     <= first;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Pulse the write enable for one cycle; call only while the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Write the mode with random upper bits; only bit 0 counts.
  task automatic set_mode(input logic evolving);
    logic [DATA_W-1:0] val;
    val    = $urandom;
    val[0] = evolving;
    cfg_write(CFG_EVOLVING, val);
  endtask

  // One random phase: set the key, then stream mostly well-formed buffers
  // (first chunk marked, random sizes and data) mixed with loose chunks.
  task automatic run_phase(input logic [DATA_W-1:0] seed, input logic evolving,
                           input bit idle, input bit hold, input bit pause_mid);
    int unsigned sent;
    int unsigned len;
    bit          paused;
    logic [CODE_W-1:0] size;
    sent   = 0;
    paused = 1'b0;
    wait_drained();
    cfg_write(CFG_KEY_SEED, seed);
    set_mode(evolving);
    tx_idle_en = idle;
    rx_idle_en = idle;
    // hold the receiver off while the sender keeps offering chunks
    if (hold) hold_requests++;
    while (sent < PHASE_ITEMS) begin
      if (pause_mid && !paused && sent >= PHASE_ITEMS / 2) begin
        // pause the sender until the block has handed back every result
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_chunk($urandom, CODE_W'($urandom_range(3)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < len; i++) begin
          size = ($urandom_range(19) == 0) ? SIZE_ODD : CODE_W'($urandom_range(2));
          send_chunk($urandom, size, i == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    // drive every input to a known value before reset releases
    cfg_we                = 1'b0;
    cfg_idx               = CFG_KEY_SEED;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.chunk_data      = '0;
    in_ch.chunk_size_code = SIZE_BYTE;
    in_ch.first_chunk     = 1'b0;
    out_ch.ready          = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // Reset settings: fixed mode, zero key.
    send_chunk(32'hFFFF_FFFF, SIZE_WORD, 1'b1);

    // Fixed all-ones key: every size, upper bits that must be ignored,
    // the unused size code, first_chunk without effect.
    wait_drained();
    cfg_write(CFG_KEY_SEED, 32'hFFFF_FFFF);
    send_chunk(32'h0000_0000, SIZE_BYTE, 1'b0);
    send_chunk(32'hFFFF_FFFF, SIZE_BYTE, 1'b1);
    send_chunk(32'h1234_ABCD, SIZE_HALF, 1'b0);
    send_chunk(32'hA5A5_A5A5, SIZE_WORD, 1'b0);
    send_chunk(32'h5A5A_5A5A, SIZE_ODD, 1'b1);

    // Fixed mode picks up a new seed at once.
    wait_drained();
    cfg_write(CFG_KEY_SEED, 32'h8000_0001);
    send_chunk(32'h0000_0000, SIZE_WORD, 1'b0);

    // Evolving mode with no first chunk yet: the running key starts at zero.
    wait_drained();
    set_mode(1'b1);
    send_chunk(32'hDEAD_BEEF, SIZE_WORD, 1'b0);
    send_chunk(32'hCAFE_F00D, SIZE_HALF, 1'b0);

    // One marked buffer through all sizes.
    send_chunk(32'h0123_4567, SIZE_WORD, 1'b1);
    send_chunk(32'h89AB_CDEF, SIZE_HALF, 1'b0);
    send_chunk(32'hFFFF_FFFF, SIZE_BYTE, 1'b0);
    send_chunk(32'h0000_0000, SIZE_ODD, 1'b0);

    // Seed written mid-buffer: the stream goes on until the next first chunk.
    wait_drained();
    cfg_write(CFG_KEY_SEED, 32'h7FFF_FFFF);
    send_chunk(32'hFFFF_FFFF, SIZE_WORD, 1'b0);
    send_chunk(32'hFFFF_FFFF, SIZE_WORD, 1'b1);
    send_chunk(32'h0000_0000, SIZE_BYTE, 1'b1);
    send_chunk(32'h0000_0000, SIZE_WORD, 1'b0);

    // Back to fixed mode with a zero seed.
    wait_drained();
    cfg_write(CFG_KEY_SEED, 32'h0000_0000);
    set_mode(1'b0);
    send_chunk(32'hFFFF_FFFF, SIZE_HALF, 1'b1);
    send_chunk(32'h8000_0000, SIZE_WORD, 1'b0);

    // ---- random part: several key settings, extremes among them ----
    run_phase(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase($urandom,      1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase($urandom,      1'b1, 1'b0, 1'b0, 1'b0);  // no idling at all
    run_phase(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1);
    run_phase($urandom,      1'b1, 1'b1, 1'b0, 1'b1);
    run_phase(32'h0000_0001, 1'b1, 1'b1, 1'b0, 1'b0);

    // drain, then allow for the block's latency before the verdict
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("lcg_keystream_xor_masker_top regression: pass");
    else
      $display("lcg_keystream_xor_masker_top regression: fail");
    $finish;
  end

endmodule
